// ----- hw/rtl/i2c_sensor_transaction_master_macros.svh -----
// ---------------------------------------------------------------------------
// I2C sensor transaction master: assertion macros
// Shared concurrent assertion forms used by ismt_back.
// ---------------------------------------------------------------------------
`ifndef I2C_SENSOR_TRANSACTION_MASTER_MACROS_SVH
`define I2C_SENSOR_TRANSACTION_MASTER_MACROS_SVH

// same-cycle implication
`define ISMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ismt assertion failed");

// next-cycle implication
`define ISMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ismt assertion failed");

`endif

// ----- hw/rtl/ismt_pkg.sv -----
// ---------------------------------------------------------------------------
// ismt_pkg
// Types and constants shared by the I2C sensor transaction master.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package ismt_pkg;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ADDR_NAK = 2'd1;
   localparam logic [1:0] STATUS_CMD_NAK  = 2'd2;

   localparam logic [7:0] MSB_MASK     = 8'h80;
   localparam logic [7:0] RESET_ADDR   = 8'd70;
   localparam logic [2:0] LAST_BIT     = 3'd7;

   typedef enum logic [1:0] {
      CLS_TICK  = 2'b00,
      CLS_WRITE = 2'b01,
      CLS_READ  = 2'b10
   } item_cls_type;

   typedef struct packed {
      item_cls_type cls;
      logic [7:0]   command_byte;
      logic         sda_in;
   } item_type;

   typedef enum logic [17:0] {
      P_IDLE    = 18'h00001,
      P_ST1     = 18'h00002,
      P_ST2     = 18'h00004,
      P_ST3     = 18'h00008,
      P_TX_SET  = 18'h00010,
      P_TX_HIGH = 18'h00020,
      P_TX_LOW  = 18'h00040,
      P_AK_REL  = 18'h00080,
      P_AK_HIGH = 18'h00100,
      P_AK_LOW  = 18'h00200,
      P_RX_HIGH = 18'h00400,
      P_RX_LOW  = 18'h00800,
      P_MA_SET  = 18'h01000,
      P_MA_HIGH = 18'h02000,
      P_MA_LOW  = 18'h04000,
      P_SP_LOW  = 18'h08000,
      P_SP_HIGH = 18'h10000,
      P_DONE    = 18'h20000
   } phase_type;

endpackage

// ----- hw/rtl/ismt_front.sv -----
// ---------------------------------------------------------------------------
// ismt_front
// Accepts requests, classifies the kind and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module ismt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_command_byte,
   input  logic                  req_sda_in,
   output ismt_pkg::item_type    q_item,
   input  logic                  q_pop,
   output logic                  q_valid
);
   import ismt_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;
   logic       pop;

   always_comb begin
      unique case (req_kind)
         KIND_WRITE: new_item.cls = CLS_WRITE;
         KIND_READ:  new_item.cls = CLS_READ;
         default:    new_item.cls = CLS_TICK;
      endcase
      new_item.command_byte = req_command_byte;
      new_item.sda_in       = req_sda_in;
   end

   assign req_stall = (count_ff == 2'd2);
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- hw/rtl/ismt_back.sv -----
// ---------------------------------------------------------------------------
// ismt_back
// Bus phase sequencer: one queued tick per step, result held in an output
// register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_sensor_transaction_master_macros.svh"
module ismt_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data,
   input  ismt_pkg::item_type    q_item,
   input  logic                  q_valid,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_scl_out,
   output logic                  rsp_sda_out,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_measurement
);
   import ismt_pkg::*;

   logic [7:0]  addr_ff;
   phase_type   phase_ff, phase_in;
   logic        op_ff, op_in;
   logic [2:0]  bit_ff, bit_in;
   logic        byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] reading_ff, reading_in;
   logic [1:0]  status_ff, status_in;

   logic        out_valid_ff;
   logic        scl_ff, sda_ff, busy_ff, done_ff;
   logic [1:0]  st_out_ff;
   logic [15:0] meas_ff;

   phase_type   ph;
   logic        op_v, byte_v;
   logic [2:0]  bit_v;
   logic [7:0]  shift_v, held_v;
   logic [15:0] reading_v;
   logic [1:0]  status_v;
   logic        scl_v, sda_v, busy_v, b_v;
   logic        pop;

   assign pop   = q_valid && (!out_valid_ff || !rsp_stall);
   assign q_pop = pop;

   always_comb begin
      ph        = phase_ff;
      op_v      = op_ff;
      bit_v     = bit_ff;
      byte_v    = byte_ff;
      shift_v   = shift_ff;
      held_v    = held_ff;
      reading_v = reading_ff;
      status_v  = status_ff;
      if ((phase_ff == P_IDLE || phase_ff == P_DONE) && (q_item.cls != CLS_TICK)) begin
         op_v      = (q_item.cls == CLS_READ);
         shift_v   = addr_ff | {7'd0, op_v};
         held_v    = q_item.command_byte;
         bit_v     = 3'd0;
         byte_v    = 1'b0;
         status_v  = STATUS_OK;
         if (op_v) begin
            reading_v = 16'd0;
         end
         ph        = P_ST1;
      end

      b_v = |(shift_v & MSB_MASK);
      unique case (ph)
         P_ST2:     begin scl_v = 1'b1; sda_v = 1'b0; end
         P_ST3:     begin scl_v = 1'b0; sda_v = 1'b0; end
         P_TX_SET:  begin scl_v = 1'b0; sda_v = b_v; end
         P_TX_HIGH: begin scl_v = 1'b1; sda_v = b_v; end
         P_TX_LOW:  begin scl_v = 1'b0; sda_v = (bit_v == LAST_BIT) ? 1'b1 : b_v; end
         P_AK_REL:  begin scl_v = 1'b0; sda_v = 1'b1; end
         P_AK_LOW:  begin scl_v = 1'b0; sda_v = 1'b1; end
         P_RX_LOW:  begin scl_v = 1'b0; sda_v = 1'b1; end
         P_MA_SET:  begin scl_v = 1'b0; sda_v = byte_v; end
         P_MA_HIGH: begin scl_v = 1'b1; sda_v = byte_v; end
         P_MA_LOW:  begin scl_v = 1'b0; sda_v = byte_v; end
         P_SP_LOW:  begin scl_v = 1'b0; sda_v = 1'b0; end
         P_SP_HIGH: begin scl_v = 1'b1; sda_v = 1'b0; end
         default:   begin scl_v = 1'b1; sda_v = 1'b1; end
      endcase
      busy_v = !(ph == P_IDLE || ph == P_DONE);

      phase_in   = ph;
      op_in      = op_v;
      bit_in     = bit_v;
      byte_in    = byte_v;
      shift_in   = shift_v;
      held_in    = held_v;
      reading_in = reading_v;
      status_in  = status_v;
      unique case (ph)
         P_ST1:     phase_in = P_ST2;
         P_ST2:     phase_in = P_ST3;
         P_ST3:     begin phase_in = P_TX_SET; bit_in = 3'd0; end
         P_TX_SET:  phase_in = P_TX_HIGH;
         P_TX_HIGH: phase_in = P_TX_LOW;
         P_TX_LOW: begin
            shift_in = {shift_v[6:0], 1'b0};
            if (bit_v == LAST_BIT) begin
               bit_in   = 3'd0;
               phase_in = P_AK_REL;
            end else begin
               bit_in   = bit_v + 3'd1;
               phase_in = P_TX_SET;
            end
         end
         P_AK_REL:  phase_in = P_AK_HIGH;
         P_AK_HIGH: begin
            if (q_item.sda_in) begin
               status_in = byte_v ? STATUS_CMD_NAK : STATUS_ADDR_NAK;
            end
            phase_in = P_AK_LOW;
         end
         P_AK_LOW: begin
            priority if (status_v != STATUS_OK || byte_v) begin
               phase_in = P_SP_LOW;
            end else if (!op_v) begin
               shift_in = held_v;
               byte_in  = 1'b1;
               bit_in   = 3'd0;
               phase_in = P_TX_SET;
            end else begin
               shift_in = 8'd0;
               bit_in   = 3'd0;
               phase_in = P_RX_HIGH;
            end
         end
         P_RX_HIGH: begin
            shift_in = {shift_v[6:0], q_item.sda_in};
            phase_in = P_RX_LOW;
         end
         P_RX_LOW: begin
            if (bit_v == LAST_BIT) begin
               if (byte_v) begin
                  reading_in = {reading_v[15:8], shift_v};
               end else begin
                  reading_in = {shift_v, 8'd0};
               end
               bit_in   = 3'd0;
               phase_in = P_MA_SET;
            end else begin
               bit_in   = bit_v + 3'd1;
               phase_in = P_RX_HIGH;
            end
         end
         P_MA_SET:  phase_in = P_MA_HIGH;
         P_MA_HIGH: phase_in = P_MA_LOW;
         P_MA_LOW: begin
            if (byte_v) begin
               phase_in = P_SP_LOW;
            end else begin
               byte_in  = 1'b1;
               shift_in = 8'd0;
               bit_in   = 3'd0;
               phase_in = P_RX_HIGH;
            end
         end
         P_SP_LOW:  phase_in = P_SP_HIGH;
         P_SP_HIGH: phase_in = P_DONE;
         default:   phase_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= RESET_ADDR;
      end else if (csr_wr_en) begin
         addr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         op_ff        <= 1'b0;
         bit_ff       <= 3'd0;
         byte_ff      <= 1'b0;
         shift_ff     <= 8'd0;
         held_ff      <= 8'd0;
         reading_ff   <= 16'd0;
         status_ff    <= STATUS_OK;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff   <= phase_in;
            op_ff      <= op_in;
            bit_ff     <= bit_in;
            byte_ff    <= byte_in;
            shift_ff   <= shift_in;
            held_ff    <= held_in;
            reading_ff <= reading_in;
            status_ff  <= status_in;
         end
         if (pop) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         scl_ff    <= scl_v;
         sda_ff    <= sda_v;
         busy_ff   <= busy_v;
         done_ff   <= (phase_ff == P_DONE);
         st_out_ff <= status_ff;
         meas_ff   <= reading_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl_out     = scl_ff;
   assign rsp_sda_out     = sda_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_done_res    = done_ff;
   assign rsp_status      = st_out_ff;
   assign rsp_measurement = meas_ff;

   `ISMT_ASSERT_NEXT(a_done_flag, clock, reset, pop && phase_ff == P_DONE, rsp_done_res)
   `ISMT_ASSERT_NEXT(a_stop_to_done, clock, reset, pop && phase_ff == P_SP_HIGH,
                     phase_ff == P_DONE)
   `ISMT_ASSERT_IMPL(a_done_released, clock, reset, rsp_valid && rsp_done_res,
                     rsp_scl_out && rsp_sda_out)

endmodule

// ----- hw/rtl/i2c_sensor_transaction_master.sv -----
// ---------------------------------------------------------------------------
// i2c_sensor_transaction_master
// I2C master for one command write or one 16-bit measurement read per request.
// ---------------------------------------------------------------------------
// Usage:
//   Each request on the req_ channel is one bus delay tick from a prescaler.
//   req_kind asks for a command write (1) or a measurement read (2); it is
//   ignored while a transaction is in progress. req_sda_in is the sampled SDA.
//   Every request yields exactly one result on the rsp_ channel: the SCL and
//   SDA drive levels for that tick, busy and done flags, the status of the
//   last transaction and the last measurement.
//   The target address byte is written through csr_wr_en / csr_wr_data while
//   the block is idle; it resets to 70.
//   Each request is written into the queue and, once popped, its result is
//   registered in the output register that drives rsp_valid. Throughput:
//   one request per cycle while rsp_stall is low, one sequencer phase step per
//   request; a two-entry queue separates intake from sequencing.
//   When the receiver stalls, the result is held, the queue fills and
//   req_stall rises once it holds two requests.
//   Reset (synchronous) empties the queue, returns the bus phase to idle and
//   clears the held status and measurement; rsp_ outputs but rsp_valid are not reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module i2c_sensor_transaction_master (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_command_byte,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_measurement
);
   import ismt_pkg::*;

   item_type      q_item;
   logic          q_valid;
   logic          q_pop;

   ismt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_command_byte (req_command_byte),
      .req_sda_in       (req_sda_in),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .q_valid          (q_valid)
   );

   ismt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_item          (q_item),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_scl_out     (rsp_scl_out),
      .rsp_sda_out     (rsp_sda_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_status      (rsp_status),
      .rsp_measurement (rsp_measurement)
   );

endmodule
